@@ src/sgga_pkg.sv @@
// Shared types and constants of the softmax gradient Gram accumulator.
// Holds the command codes, register indexes, fixed widths and the controller/datapath structs.
// No dependencies.
package sgga_pkg;

	localparam int ENTRY_W = 48;
	localparam int PROB_W  = 16;
	localparam int FEAT_W  = 16;
	localparam int VALUE_W = 17;
	localparam int H_W     = 17;
	localparam int PROD_W  = 34;
	localparam int XX_W    = 32;
	localparam int WORD_W  = ENTRY_W + 1;
	localparam int CFG_W   = 5;

	localparam logic [2:0] FUNC_LOAD_PROB = 3'd0;
	localparam logic [2:0] FUNC_LOAD_FEAT = 3'd1;
	localparam logic [2:0] FUNC_ACCUM     = 3'd2;
	localparam logic [2:0] FUNC_READ      = 3'd3;
	localparam logic [2:0] FUNC_CLEAR     = 3'd4;

	localparam logic CFG_NUM_LABELS = 1'b0;
	localparam logic CFG_NUM_DIMS   = 1'b1;

	localparam logic [3:0] NUM_LABELS_RST = 4'd8;
	localparam logic [4:0] NUM_DIMS_RST   = 5'd16;

	localparam logic [PROB_W-1:0] PROB_ONE = 16'h8000;
	localparam logic [FEAT_W-1:0] FEAT_MAX = 16'h7FFF;

	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic load_prob;
		logic load_feat;
		logic take_read;
		logic clr_wr;
		logic latch_pp;
		logic latch_pq;
		logic sum_clear;
		logic sum_en;
		logic k_is_p;
		logic k_is_q;
		logic s_round;
		logic latch_xi;
		logic upd_issue;
		logic rd_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

@@ src/sgga_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sgga_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/sgga_dp.sv @@
// Datapath: configuration registers, probability and feature vectors, the h-product pipeline,
// the pair-sum accumulator and the read-modify-write pipeline on the entry store.
// Depends on sgga_pkg and sgga_ram.
module sgga_dp #(
	parameter int MAX_LABELS = 8,
	parameter int MAX_DIMS   = 16,
	parameter int LW         = 3,
	parameter int DW         = 4,
	parameter int RW         = 7,
	parameter int AW         = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [sgga_pkg::CFG_W-1:0]           cfg_data,
	input  logic [3:0]                           index,
	input  logic [6:0]                           row,
	input  logic [6:0]                           col,
	input  logic signed [sgga_pkg::VALUE_W-1:0]  value,
	input  sgga_pkg::cmd_t                       cmd,
	input  logic [LW-1:0]                        sel_lbl,
	input  logic [DW-1:0]                        sel_dim,
	input  logic [RW-1:0]                        row_idx,
	input  logic [RW-1:0]                        col_idx,
	input  logic [AW-1:0]                        clr_addr,
	output logic [LW-1:0]                        labs_m1,
	output logic [DW-1:0]                        dims_m1,
	output sgga_pkg::status_t                    status,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sgga_pkg::ENTRY_W-1:0]  entry,
	output logic                                 saturated
);

	localparam int SIDE  = MAX_LABELS * MAX_DIMS;
	localparam int DEPTH = SIDE * SIDE;
	localparam int SW    = 33 + LW;
	localparam int S16W  = SW - 13;
	localparam int TW    = sgga_pkg::XX_W + S16W;
	localparam int SUMW  = TW + 1;
	localparam logic signed [sgga_pkg::PROD_W-1:0] H_HALF = 34'sd16384;
	localparam logic signed [SW-1:0] S_HALF = SW'(8192);

	logic [3:0] num_labels_q;
	logic [4:0] num_dims_q;
	logic [sgga_pkg::PROB_W-1:0] prob_q [MAX_LABELS];
	logic signed [sgga_pkg::FEAT_W-1:0] feat_q [MAX_DIMS];

	int labs_c;
	int dims_c;
	logic [sgga_pkg::PROB_W-1:0] prob_in_c;
	logic [sgga_pkg::FEAT_W-1:0] feat_in_c;

	logic [sgga_pkg::PROB_W-1:0] pp_q;
	logic [sgga_pkg::PROB_W-1:0] pq_q;
	logic [sgga_pkg::PROB_W-1:0] pk_c;
	logic signed [sgga_pkg::H_W-1:0] dp_c;
	logic signed [sgga_pkg::H_W-1:0] dq_c;
	logic hv_s1;
	logic hv_s2;
	logic signed [sgga_pkg::PROD_W-1:0] prod_p_s1;
	logic signed [sgga_pkg::PROD_W-1:0] prod_q_s1;
	logic signed [sgga_pkg::H_W-1:0] hp_c;
	logic signed [sgga_pkg::H_W-1:0] hq_c;
	logic signed [sgga_pkg::PROD_W-1:0] hh_s2;
	logic signed [SW-1:0] s_acc_q;
	logic signed [S16W-1:0] s16_q;

	logic signed [sgga_pkg::FEAT_W-1:0] xi_q;
	logic signed [sgga_pkg::FEAT_W-1:0] xj_c;
	logic [AW-1:0] upd_addr_c;
	logic uv_s1;
	logic uv_s2;
	logic signed [sgga_pkg::XX_W-1:0] xx_s1;
	logic [AW-1:0] addr_s1;
	logic [AW-1:0] addr_s2;
	logic signed [TW-1:0] term_s2;
	logic [sgga_pkg::WORD_W-1:0] rd_s2;
	logic signed [SUMW-1:0] sum_c;
	logic ovf_hi_c;
	logic ovf_lo_c;
	logic signed [sgga_pkg::ENTRY_W-1:0] new_entry_c;

	logic [AW-1:0] rd_addr_q;
	logic rd_ok_q;
	logic out_valid_q;
	logic signed [sgga_pkg::ENTRY_W-1:0] entry_q;
	logic sat_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [sgga_pkg::WORD_W-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [sgga_pkg::WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_labels_q <= sgga_pkg::NUM_LABELS_RST;
			num_dims_q   <= sgga_pkg::NUM_DIMS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sgga_pkg::CFG_NUM_LABELS: num_labels_q <= cfg_data[3:0];
				sgga_pkg::CFG_NUM_DIMS:   num_dims_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_labels_q == 4'd0) begin
			labs_c = 1;
		end else if (int'(num_labels_q) > MAX_LABELS) begin
			labs_c = MAX_LABELS;
		end else begin
			labs_c = int'(num_labels_q);
		end
		if (num_dims_q == 5'd0) begin
			dims_c = 1;
		end else if (int'(num_dims_q) > MAX_DIMS) begin
			dims_c = MAX_DIMS;
		end else begin
			dims_c = int'(num_dims_q);
		end
	end

	assign labs_m1 = LW'(labs_c - 1);
	assign dims_m1 = DW'(dims_c - 1);

	always_comb begin
		if (value[16]) begin
			prob_in_c = '0;
		end else if (value[15:0] > sgga_pkg::PROB_ONE) begin
			prob_in_c = sgga_pkg::PROB_ONE;
		end else begin
			prob_in_c = value[15:0];
		end
		if (!value[16] && value[15]) begin
			feat_in_c = sgga_pkg::FEAT_MAX;
		end else begin
			feat_in_c = value[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MAX_LABELS; n++) begin
				prob_q[n] <= '0;
			end
			for (int n = 0; n < MAX_DIMS; n++) begin
				feat_q[n] <= '0;
			end
		end else begin
			if (cmd.load_prob && int'(index) < MAX_LABELS) begin
				prob_q[LW'(index)] <= prob_in_c;
			end
			if (cmd.load_feat && int'(index) < MAX_DIMS) begin
				feat_q[DW'(index)] <= feat_in_c;
			end
		end
	end

	// h products for one k per cycle, then the pair sum
	assign pk_c = prob_q[sel_lbl];
	assign dp_c = (cmd.k_is_p ? $signed({1'b0, sgga_pkg::PROB_ONE}) : 17'sd0)
		- $signed({1'b0, pk_c});
	assign dq_c = (cmd.k_is_q ? $signed({1'b0, sgga_pkg::PROB_ONE}) : 17'sd0)
		- $signed({1'b0, pk_c});

	assign hp_c = sgga_pkg::H_W'((prod_p_s1 + H_HALF) >>> 15);
	assign hq_c = sgga_pkg::H_W'((prod_q_s1 + H_HALF) >>> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s1 <= 1'b0;
			hv_s2 <= 1'b0;
		end else begin
			hv_s1 <= cmd.sum_en;
			hv_s2 <= hv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_pp) begin
			pp_q <= pk_c;
		end
		if (cmd.latch_pq) begin
			pq_q <= pk_c;
		end
		prod_p_s1 <= $signed({1'b0, pp_q}) * dp_c;
		prod_q_s1 <= $signed({1'b0, pq_q}) * dq_c;
		hh_s2     <= hp_c * hq_c;
		if (cmd.sum_clear) begin
			s_acc_q <= '0;
		end else if (hv_s2) begin
			s_acc_q <= s_acc_q + SW'(hh_s2);
		end
		if (cmd.s_round) begin
			s16_q <= S16W'((s_acc_q + S_HALF) >>> 14);
		end
	end

	// read-modify-write over the store
	assign xj_c       = feat_q[sel_dim];
	assign upd_addr_c = AW'(int'(row_idx) * SIDE + int'(col_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_s1 <= 1'b0;
			uv_s2 <= 1'b0;
		end else begin
			uv_s1 <= cmd.upd_issue;
			uv_s2 <= uv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_xi) begin
			xi_q <= xj_c;
		end
		xx_s1   <= xi_q * xj_c;
		addr_s1 <= upd_addr_c;
		term_s2 <= TW'(xx_s1) * TW'(s16_q);
		rd_s2   <= ram_rdata;
		addr_s2 <= addr_s1;
	end

	assign sum_c    = SUMW'($signed(rd_s2[sgga_pkg::ENTRY_W-1:0])) + SUMW'(term_s2);
	assign ovf_hi_c = sum_c > SUMW'(sgga_pkg::ENTRY_MAX);
	assign ovf_lo_c = sum_c < SUMW'(sgga_pkg::ENTRY_MIN);

	always_comb begin
		if (ovf_hi_c) begin
			new_entry_c = sgga_pkg::ENTRY_MAX;
		end else if (ovf_lo_c) begin
			new_entry_c = sgga_pkg::ENTRY_MIN;
		end else begin
			new_entry_c = sgga_pkg::ENTRY_W'(sum_c);
		end
	end

	always_comb begin
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr;
			ram_wdata = '0;
		end else begin
			ram_we    = uv_s2;
			ram_waddr = addr_s2;
			ram_wdata = {rd_s2[sgga_pkg::ENTRY_W] | ovf_hi_c | ovf_lo_c, new_entry_c};
		end
	end

	assign ram_re    = cmd.upd_issue | cmd.rd_issue;
	assign ram_raddr = cmd.rd_issue ? rd_addr_q : upd_addr_c;

	sgga_ram #(
		.WIDTH(sgga_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read command and result register
	always_ff @(posedge clk) begin
		if (cmd.take_read) begin
			rd_addr_q <= AW'(int'(row) * SIDE + int'(col));
			rd_ok_q   <= (int'(row) < labs_c * dims_c) && (int'(col) < labs_c * dims_c);
		end
		if (cmd.out_load) begin
			entry_q <= rd_ok_q ? $signed(ram_rdata[sgga_pkg::ENTRY_W-1:0]) : '0;
			sat_q   <= rd_ok_q & ram_rdata[sgga_pkg::ENTRY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign entry           = entry_q;
	assign saturated       = sat_q;

`ifndef NO_ASSERTIONS
	a_clr_no_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && uv_s2))
		else $error("clear write collides with an update write");
	a_round_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.s_round |-> (!hv_s1 && !hv_s2))
		else $error("pair sum rounded while products in flight");
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten before its beat");
`endif

endmodule

@@ src/sgga_ctrl.sv @@
// Controller: accepts items, sequences the clearing sweep, the accumulate loops and reads.
// Depends on sgga_pkg.
module sgga_ctrl #(
	parameter int MAX_LABELS = 8,
	parameter int MAX_DIMS   = 16,
	parameter int LW         = 3,
	parameter int DW         = 4,
	parameter int RW         = 7,
	parameter int AW         = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        func,
	input  logic [LW-1:0]     labs_m1,
	input  logic [DW-1:0]     dims_m1,
	input  sgga_pkg::status_t status,
	output sgga_pkg::cmd_t    cmd,
	output logic [LW-1:0]     sel_lbl,
	output logic [DW-1:0]     sel_dim,
	output logic [RW-1:0]     row_idx,
	output logic [RW-1:0]     col_idx,
	output logic [AW-1:0]     clr_addr
);

	localparam int DEPTH = MAX_LABELS * MAX_DIMS * MAX_LABELS * MAX_DIMS;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_CLEAR  = 12'b0000_0000_0010,
		S_PREP_P = 12'b0000_0000_0100,
		S_PREP_Q = 12'b0000_0000_1000,
		S_HSUM   = 12'b0000_0001_0000,
		S_HWAIT  = 12'b0000_0010_0000,
		S_SROUND = 12'b0000_0100_0000,
		S_LOADX  = 12'b0000_1000_0000,
		S_UPD    = 12'b0001_0000_0000,
		S_DRAIN  = 12'b0010_0000_0000,
		S_RISSUE = 12'b0100_0000_0000,
		S_RDATA  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic [LW-1:0] p_q;
	logic [LW-1:0] q_q;
	logic [LW-1:0] k_q;
	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	logic [RW-1:0] pbase_q;
	logic [RW-1:0] qbase_q;
	logic [AW-1:0] clr_q;
	logic wcnt_q;
	logic accept;
	logic [RW-1:0] dims_r;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign dims_r   = RW'(dims_m1) + RW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			p_q     <= '0;
			q_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pbase_q <= '0;
			qbase_q <= '0;
			clr_q   <= '0;
			wcnt_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							sgga_pkg::FUNC_ACCUM: begin
								state_q <= S_PREP_P;
								p_q     <= '0;
								q_q     <= '0;
								pbase_q <= '0;
								qbase_q <= '0;
							end
							sgga_pkg::FUNC_READ: state_q <= S_RISSUE;
							sgga_pkg::FUNC_CLEAR: begin
								state_q <= S_CLEAR;
								clr_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_PREP_P: state_q <= S_PREP_Q;
				S_PREP_Q: begin
					state_q <= S_HSUM;
					k_q     <= '0;
				end
				S_HSUM: begin
					if (k_q == labs_m1) begin
						state_q <= S_HWAIT;
						wcnt_q  <= 1'b0;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				S_HWAIT: begin
					wcnt_q <= 1'b1;
					if (wcnt_q) begin
						state_q <= S_SROUND;
					end
				end
				S_SROUND: begin
					state_q <= S_LOADX;
					i_q     <= '0;
				end
				S_LOADX: begin
					state_q <= S_UPD;
					j_q     <= '0;
				end
				S_UPD: begin
					if (j_q != dims_m1) begin
						j_q <= j_q + DW'(1);
					end else if (i_q != dims_m1) begin
						i_q     <= i_q + DW'(1);
						state_q <= S_LOADX;
					end else if (q_q != labs_m1) begin
						q_q     <= q_q + LW'(1);
						qbase_q <= qbase_q + dims_r;
						state_q <= S_PREP_P;
					end else if (p_q != labs_m1) begin
						q_q     <= '0;
						qbase_q <= '0;
						p_q     <= p_q + LW'(1);
						pbase_q <= pbase_q + dims_r;
						state_q <= S_PREP_P;
					end else begin
						state_q <= S_DRAIN;
						wcnt_q  <= 1'b0;
					end
				end
				S_DRAIN: begin
					wcnt_q <= 1'b1;
					if (wcnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_RISSUE: state_q <= S_RDATA;
				S_RDATA: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		sel_lbl       = k_q;
		sel_dim       = j_q;
		cmd.load_prob = accept && (func == sgga_pkg::FUNC_LOAD_PROB);
		cmd.load_feat = accept && (func == sgga_pkg::FUNC_LOAD_FEAT);
		cmd.take_read = accept && (func == sgga_pkg::FUNC_READ);
		case (state_q)
			S_CLEAR:  cmd.clr_wr = 1'b1;
			S_PREP_P: begin
				sel_lbl      = p_q;
				cmd.latch_pp = 1'b1;
			end
			S_PREP_Q: begin
				sel_lbl       = q_q;
				cmd.latch_pq  = 1'b1;
				cmd.sum_clear = 1'b1;
			end
			S_HSUM: begin
				cmd.sum_en = 1'b1;
				cmd.k_is_p = (k_q == p_q);
				cmd.k_is_q = (k_q == q_q);
			end
			S_SROUND: cmd.s_round = 1'b1;
			S_LOADX: begin
				sel_dim      = i_q;
				cmd.latch_xi = 1'b1;
			end
			S_UPD:    cmd.upd_issue = 1'b1;
			S_RISSUE: cmd.rd_issue = 1'b1;
			S_RDATA:  cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	assign row_idx  = pbase_q + RW'(i_q);
	assign col_idx  = qbase_q + RW'(j_q);
	assign clr_addr = clr_q;

`ifndef NO_ASSERTIONS
	a_ram_users: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.upd_issue, cmd.rd_issue}))
		else $error("more than one store access issued");
	a_accum_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == sgga_pkg::FUNC_ACCUM) |=> (state_q == S_PREP_P && p_q == '0))
		else $error("accumulate did not start at the first pair");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HSUM) |-> (k_q <= labs_m1))
		else $error("class loop ran past the used labels");
`endif

endmodule

@@ src/softmax_gradient_gram_accumulator.sv @@
// Top level of the softmax gradient Gram accumulator: config port, item channels, store.
// Depends on sgga_pkg, sgga_ctrl and sgga_dp.
//
// One item at a time; in_stall is high while an item is at work. Load commands and unused
// codes leave in_stall low; a read passes an issue state and a data state, where it waits
// while out_stall holds the result register. The pass after reset sweeps the store one entry
// a cycle over all (MAX_LABELS*MAX_DIMS)^2 entries (16384 at default sizes); a clear runs
// the same sweep, no items taken meanwhile. An accumulate with L classes and D dims in use
// is bound by the store's single read-modify-write port, which updates one entry a cycle
// within each feature row after a per-class-pair sum of L products.
module softmax_gradient_gram_accumulator #(
	parameter int MAX_LABELS = 8,
	parameter int MAX_DIMS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [sgga_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          func,
	input  logic [3:0]                          index,
	input  logic [6:0]                          row,
	input  logic [6:0]                          col,
	input  logic signed [sgga_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sgga_pkg::ENTRY_W-1:0] entry,
	output logic                                saturated
);

	localparam int SIDE = MAX_LABELS * MAX_DIMS;
	localparam int LW   = $clog2(MAX_LABELS);
	localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int RW   = $clog2(SIDE);
	localparam int AW   = $clog2(SIDE * SIDE);

	sgga_pkg::cmd_t    cmd;
	sgga_pkg::status_t status;
	logic [LW-1:0] sel_lbl;
	logic [DW-1:0] sel_dim;
	logic [RW-1:0] row_idx;
	logic [RW-1:0] col_idx;
	logic [AW-1:0] clr_addr;
	logic [LW-1:0] labs_m1;
	logic [DW-1:0] dims_m1;

	sgga_ctrl #(
		.MAX_LABELS(MAX_LABELS),
		.MAX_DIMS  (MAX_DIMS),
		.LW        (LW),
		.DW        (DW),
		.RW        (RW),
		.AW        (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func    (func),
		.labs_m1 (labs_m1),
		.dims_m1 (dims_m1),
		.status  (status),
		.cmd     (cmd),
		.sel_lbl (sel_lbl),
		.sel_dim (sel_dim),
		.row_idx (row_idx),
		.col_idx (col_idx),
		.clr_addr(clr_addr)
	);

	sgga_dp #(
		.MAX_LABELS(MAX_LABELS),
		.MAX_DIMS  (MAX_DIMS),
		.LW        (LW),
		.DW        (DW),
		.RW        (RW),
		.AW        (AW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.index    (index),
		.row      (row),
		.col      (col),
		.value    (value),
		.cmd      (cmd),
		.sel_lbl  (sel_lbl),
		.sel_dim  (sel_dim),
		.row_idx  (row_idx),
		.col_idx  (col_idx),
		.clr_addr (clr_addr),
		.labs_m1  (labs_m1),
		.dims_m1  (dims_m1),
		.status   (status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.entry    (entry),
		.saturated(saturated)
	);

endmodule
